// File: sv/fixed_latency_memory_rate_limiter_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fixed latency memory rate limiter
// Shared property forms, clocked on clk_i and held off during reset.
// ----------------------------------------------------------------------------
`ifndef FIXED_LATENCY_MEMORY_RATE_LIMITER_TOP_MACROS_SVH
`define FIXED_LATENCY_MEMORY_RATE_LIMITER_TOP_MACROS_SVH

// same-cycle implication
`define FLMRL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FLMRL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/flmrl_pkg.sv
// ----------------------------------------------------------------------------
// flmrl_pkg
// Types and constants shared by the rate limiter front, back and result units.
// ----------------------------------------------------------------------------
package flmrl_pkg;

  // default sizes
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ADDR_BITS_DEF   = 48;
  localparam int CYCLE_BITS_DEF  = 48;

  // fixed field widths
  localparam int LAT_W      = 10;
  localparam int EPOCH_W    = 16;
  localparam int QUOTA_W    = 16;
  localparam int ID_W       = 32;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // result buffer: at most this many completions per tick
  localparam int MAX_RESULTS = 16;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
  localparam int RES_IDX_W   = $clog2(MAX_RESULTS);

  // command queue between front and back
  localparam int CMD_DEPTH = 2;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  // register reset values
  localparam logic [LAT_W-1:0]   LAT_RST   = LAT_W'(100);
  localparam logic [EPOCH_W-1:0] EPOCH_RST = EPOCH_W'(100);
  localparam logic [QUOTA_W-1:0] QUOTA_RST = QUOTA_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LATENCY = 2'd0,
    CFG_EPOCH   = 2'd1,
    CFG_QUOTA   = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  // end-of-tick handoff from back to result unit
  typedef struct packed {
    logic valid;
    logic still_pending;
    logic overflowed;
  } commit_t;

endpackage

// File: sv/flmrl_front.sv
// ----------------------------------------------------------------------------
// flmrl_front
// Input side: accepts items, decodes the operation and queues the commands.
// ----------------------------------------------------------------------------
module flmrl_front #(
  parameter int ADDR_BITS = flmrl_pkg::ADDR_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  output logic                 full_o,
  input  logic                 op_i,
  input  logic                 req_write_i,
  input  logic [ADDR_BITS-1:0] req_addr_i,
  output logic                 cmd_valid_o,
  output flmrl_pkg::op_e       cmd_op_o,
  output logic                 cmd_write_o,
  output logic [ADDR_BITS-1:0] cmd_addr_o,
  input  logic                 cmd_pop_i
);
  import flmrl_pkg::*;

  op_e                  op_q   [CMD_DEPTH];
  logic                 wr_q   [CMD_DEPTH];
  logic [ADDR_BITS-1:0] addr_q [CMD_DEPTH];

  logic [CMD_PTR_W-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CMD_CNT_W-1:0] cnt_q, cnt_d;
  logic                 push_acc, pop_acc;

  assign full_o      = (cnt_q == CMD_CNT_W'(CMD_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign push_acc    = push_i && !full_o;
  assign pop_acc     = cmd_pop_i && cmd_valid_o;

  assign cmd_op_o    = op_q[rp_q];
  assign cmd_write_o = wr_q[rp_q];
  assign cmd_addr_o  = addr_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_acc) begin
      wp_d = (wp_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wp_q + 1'b1;
    end
    if (pop_acc) begin
      rp_d = (rp_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rp_q + 1'b1;
    end
    case ({push_acc, pop_acc})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // decode the op bit on the way in
  always_ff @(posedge clk_i) begin
    if (push_acc) begin
      op_q[wp_q]   <= op_i ? OP_TICK : OP_ADD;
      wr_q[wp_q]   <= req_write_i;
      addr_q[wp_q] <= req_addr_i;
    end
  end

endmodule

// File: sv/flmrl_back.sv
// ----------------------------------------------------------------------------
// flmrl_back
// Request FIFO memory, cycle and epoch accounting, and the tick sequencer.
// ----------------------------------------------------------------------------
`include "fixed_latency_memory_rate_limiter_top_macros.svh"

module flmrl_back #(
  parameter int QUEUE_DEPTH = flmrl_pkg::QUEUE_DEPTH_DEF,
  parameter int ADDR_BITS   = flmrl_pkg::ADDR_BITS_DEF,
  parameter int CYCLE_BITS  = flmrl_pkg::CYCLE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [flmrl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [flmrl_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                             cmd_valid_i,
  input  flmrl_pkg::op_e                   cmd_op_i,
  input  logic                             cmd_write_i,
  input  logic [ADDR_BITS-1:0]             cmd_addr_i,
  output logic                             cmd_pop_o,
  input  logic                             res_idle_i,
  output logic                             res_we_o,
  output logic                             res_has_cmp_o,
  output logic [flmrl_pkg::ID_W-1:0]       res_id_o,
  output logic [ADDR_BITS-1:0]             res_addr_o,
  output logic                             res_write_o,
  output logic [CYCLE_BITS-1:0]            res_cycle_o,
  output flmrl_pkg::commit_t               commit_o
);
  import flmrl_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ENT_W = CYCLE_BITS + ADDR_BITS + 1 + ID_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK
  } state_e;

  state_e                state_q;
  logic [LAT_W-1:0]      lat_q;
  logic [EPOCH_W-1:0]    epoch_q;
  logic [QUOTA_W-1:0]    quota_q;
  logic [CYCLE_BITS-1:0] cycle_q;
  logic [EPOCH_W-1:0]    phase_q;
  logic [QUOTA_W-1:0]    served_q;
  logic [ID_W-1:0]       next_id_q;
  logic [PTR_W-1:0]      head_q, tail_q;
  logic [CNT_W-1:0]      fill_q;
  logic                  ovf_q;
  logic [RES_CNT_W-1:0]  n_q;

  logic [ENT_W-1:0]      mem [QUEUE_DEPTH];
  logic [ENT_W-1:0]      rd_q;
  logic [ENT_W-1:0]      wdata;

  logic [CYCLE_BITS-1:0] rd_due;
  logic [ADDR_BITS-1:0]  rd_addr;
  logic                  rd_write;
  logic [ID_W-1:0]       rd_id;

  logic [LAT_W-1:0]      lat_m1;
  logic [CYCLE_BITS-1:0] due_new;
  logic                  q_full, is_add, mem_we, can_serve;
  logic [EPOCH_W-1:0]    phase_inc;
  logic                  epoch_wrap;

  assign {rd_due, rd_addr, rd_write, rd_id} = rd_q;

  // a latency of zero gives the same due cycle as the smallest nonzero latency
  assign lat_m1  = (lat_q == '0) ? '0 : lat_q - 1'b1;
  assign due_new = cycle_q + CYCLE_BITS'(lat_m1);
  assign wdata   = {due_new, cmd_addr_i, cmd_write_i, next_id_q};

  assign q_full    = (fill_q == CNT_W'(QUEUE_DEPTH));
  assign is_add    = (cmd_op_i == OP_ADD);
  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i && (is_add || res_idle_i);
  assign mem_we    = cmd_pop_o && is_add && !q_full;

  assign can_serve = (state_q == ST_CHECK) && (fill_q != '0) &&
                     (n_q < RES_CNT_W'(MAX_RESULTS)) && (rd_due <= cycle_q) &&
                     (served_q < quota_q);

  assign phase_inc  = phase_q + 1'b1;
  assign epoch_wrap = (phase_inc >= epoch_q) || (phase_inc == '0);

  // one entry per completion, or a single empty entry for an idle tick
  assign res_we_o      = can_serve || ((state_q == ST_CHECK) && (n_q == '0));
  assign res_has_cmp_o = can_serve;
  assign res_id_o      = can_serve ? rd_id : '0;
  assign res_addr_o    = can_serve ? rd_addr : '0;
  assign res_write_o   = can_serve && rd_write;
  assign res_cycle_o   = can_serve ? cycle_q : '0;

  assign commit_o.valid         = (state_q == ST_CHECK) && !can_serve;
  assign commit_o.still_pending = (fill_q != '0);
  assign commit_o.overflowed    = ovf_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[tail_q] <= wdata;
    end
    rd_q <= mem[head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      lat_q     <= LAT_RST;
      epoch_q   <= EPOCH_RST;
      quota_q   <= QUOTA_RST;
      cycle_q   <= '0;
      phase_q   <= '0;
      served_q  <= '0;
      next_id_q <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      fill_q    <= '0;
      ovf_q     <= 1'b0;
      n_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_LATENCY: lat_q   <= cfg_wdata_i[LAT_W-1:0];
          CFG_EPOCH:   epoch_q <= cfg_wdata_i[EPOCH_W-1:0];
          CFG_QUOTA:   quota_q <= cfg_wdata_i[QUOTA_W-1:0];
          default:     ;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_pop_o) begin
            if (!is_add) begin
              n_q     <= '0;
              state_q <= ST_READ;
            end else if (q_full) begin
              ovf_q <= 1'b1;
            end else begin
              tail_q    <= (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
              fill_q    <= fill_q + 1'b1;
              next_id_q <= next_id_q + 1'b1;
            end
          end
        end
        ST_READ: begin
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          if (can_serve) begin
            head_q   <= (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
            fill_q   <= fill_q - 1'b1;
            served_q <= served_q + 1'b1;
            n_q      <= n_q + 1'b1;
            state_q  <= ST_READ;
          end else begin
            // close the tick: advance time, roll the epoch
            cycle_q <= cycle_q + 1'b1;
            phase_q <= epoch_wrap ? '0 : phase_inc;
            if (epoch_wrap) begin
              served_q <= '0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `FLMRL_ASSERT_IMPL(a_fill_bound, 1'b1, fill_q <= CNT_W'(QUEUE_DEPTH), "fill count past depth")
  `FLMRL_ASSERT_NEXT(a_ovf_sticky, ovf_q, ovf_q, "overflow flag cleared")
  `FLMRL_ASSERT_IMPL(a_res_cap, res_we_o, n_q < RES_CNT_W'(MAX_RESULTS), "tick result overrun")
  `FLMRL_ASSERT_IMPL(a_tick_start, cmd_pop_o && !is_add, res_idle_i, "tick with busy result")

endmodule

// File: sv/flmrl_out.sv
// ----------------------------------------------------------------------------
// flmrl_out
// Result buffer: gathers one tick's items and releases them once committed.
// ----------------------------------------------------------------------------
`include "fixed_latency_memory_rate_limiter_top_macros.svh"

module flmrl_out #(
  parameter int ADDR_BITS  = flmrl_pkg::ADDR_BITS_DEF,
  parameter int CYCLE_BITS = flmrl_pkg::CYCLE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       res_we_i,
  input  logic                       res_has_cmp_i,
  input  logic [flmrl_pkg::ID_W-1:0] res_id_i,
  input  logic [ADDR_BITS-1:0]       res_addr_i,
  input  logic                       res_write_i,
  input  logic [CYCLE_BITS-1:0]      res_cycle_i,
  input  flmrl_pkg::commit_t         commit_i,
  output logic                       idle_o,
  output logic                       empty_o,
  input  logic                       pop_i,
  output logic                       has_completion_o,
  output logic [flmrl_pkg::ID_W-1:0] done_id_o,
  output logic [ADDR_BITS-1:0]       done_addr_o,
  output logic                       done_write_o,
  output logic [CYCLE_BITS-1:0]      done_cycle_o,
  output logic                       still_pending_o,
  output logic                       overflowed_o,
  output logic                       last_o
);
  import flmrl_pkg::*;

  logic                  hc_q   [MAX_RESULTS];
  logic [ID_W-1:0]       id_q   [MAX_RESULTS];
  logic [ADDR_BITS-1:0]  addr_q [MAX_RESULTS];
  logic                  wr_q   [MAX_RESULTS];
  logic [CYCLE_BITS-1:0] cyc_q  [MAX_RESULTS];

  logic [RES_CNT_W-1:0]  wcnt_q;
  logic [RES_IDX_W-1:0]  rd_q;
  logic                  pub_q;
  logic                  sp_q, ovf_q;
  logic                  pop_acc;

  assign empty_o = !pub_q;
  assign idle_o  = (wcnt_q == '0) && !pub_q;
  assign pop_acc = pop_i && pub_q;
  assign last_o  = ({1'b0, rd_q} == (wcnt_q - 1'b1));

  assign has_completion_o = hc_q[rd_q];
  assign done_id_o        = id_q[rd_q];
  assign done_addr_o      = addr_q[rd_q];
  assign done_write_o     = wr_q[rd_q];
  assign done_cycle_o     = cyc_q[rd_q];
  assign still_pending_o  = sp_q;
  assign overflowed_o     = ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcnt_q <= '0;
      rd_q   <= '0;
      pub_q  <= 1'b0;
    end else begin
      if (res_we_i) begin
        wcnt_q <= wcnt_q + 1'b1;
      end
      if (commit_i.valid) begin
        pub_q <= 1'b1;
      end
      if (pop_acc) begin
        if (last_o) begin
          // tick fully drained: rewind
          wcnt_q <= '0;
          rd_q   <= '0;
          pub_q  <= 1'b0;
        end else begin
          rd_q <= rd_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_we_i) begin
      hc_q[wcnt_q[RES_IDX_W-1:0]]   <= res_has_cmp_i;
      id_q[wcnt_q[RES_IDX_W-1:0]]   <= res_id_i;
      addr_q[wcnt_q[RES_IDX_W-1:0]] <= res_addr_i;
      wr_q[wcnt_q[RES_IDX_W-1:0]]   <= res_write_i;
      cyc_q[wcnt_q[RES_IDX_W-1:0]]  <= res_cycle_i;
    end
    if (commit_i.valid) begin
      sp_q  <= commit_i.still_pending;
      ovf_q <= commit_i.overflowed;
    end
  end

  `FLMRL_ASSERT_IMPL(a_pub_nonempty, pub_q, wcnt_q != '0, "published tick has no items")
  `FLMRL_ASSERT_IMPL(a_no_late_write, pub_q, !res_we_i, "write into published tick")
  `FLMRL_ASSERT_NEXT(a_last_drains, pop_acc && last_o, empty_o, "items left after last")

endmodule

// File: sv/fixed_latency_memory_rate_limiter_top.sv
// ----------------------------------------------------------------------------
// fixed_latency_memory_rate_limiter_top
// Fixed-latency memory model with a per-epoch completion cap.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake          Payload
//  -------   ---------          -------
//  input     push_i / full_o    op_i, req_write_i, req_addr_i
//  result    pop_i / empty_o    has_completion_o, done_id_o, done_addr_o,
//                               done_write_o, done_cycle_o, still_pending_o,
//                               overflowed_o, last_o
//  config    cfg_we_i           cfg_idx_i, cfg_wdata_i (no wait, no read-back)
//
//  An add is taken straight from the idle state. A tick is taken in the idle
//  state, then runs a registered head read plus a check per completion, and a
//  last read and check that close the tick.
//  A tick starts only after the previous tick's results have all been
//  transferred out; adds ahead of it keep flowing through the command queue.
//  Reset is asynchronous, active low; the request memory needs no clearing.
//
// ----------------------------------------------------------------------------
module fixed_latency_memory_rate_limiter_top #(
  parameter int QUEUE_DEPTH = flmrl_pkg::QUEUE_DEPTH_DEF,
  parameter int ADDR_BITS   = flmrl_pkg::ADDR_BITS_DEF,
  parameter int CYCLE_BITS  = flmrl_pkg::CYCLE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration writes
  input  logic                             cfg_we_i,
  input  logic [flmrl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [flmrl_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // input items
  input  logic                             push_i,
  output logic                             full_o,
  input  logic                             op_i,
  input  logic                             req_write_i,
  input  logic [ADDR_BITS-1:0]             req_addr_i,
  // result items
  output logic                             empty_o,
  input  logic                             pop_i,
  output logic                             has_completion_o,
  output logic [flmrl_pkg::ID_W-1:0]       done_id_o,
  output logic [ADDR_BITS-1:0]             done_addr_o,
  output logic                             done_write_o,
  output logic [CYCLE_BITS-1:0]            done_cycle_o,
  output logic                             still_pending_o,
  output logic                             overflowed_o,
  output logic                             last_o
);
  import flmrl_pkg::*;

  // front to back command
  logic                  cmd_valid, cmd_pop, cmd_write;
  op_e                   cmd_op;
  logic [ADDR_BITS-1:0]  cmd_addr;

  // back to result buffer
  logic                  res_idle, res_we, res_has_cmp, res_write;
  logic [ID_W-1:0]       res_id;
  logic [ADDR_BITS-1:0]  res_addr;
  logic [CYCLE_BITS-1:0] res_cycle;
  commit_t               commit;

  // accept and decode items; hold them until the back end is free
  flmrl_front #(
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .op_i        (op_i),
    .req_write_i (req_write_i),
    .req_addr_i  (req_addr_i),
    .cmd_valid_o (cmd_valid),
    .cmd_op_o    (cmd_op),
    .cmd_write_o (cmd_write),
    .cmd_addr_o  (cmd_addr),
    .cmd_pop_i   (cmd_pop)
  );

  // queue requests, advance time, drain due requests under the quota
  flmrl_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ADDR_BITS   (ADDR_BITS),
    .CYCLE_BITS  (CYCLE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_valid_i   (cmd_valid),
    .cmd_op_i      (cmd_op),
    .cmd_write_i   (cmd_write),
    .cmd_addr_i    (cmd_addr),
    .cmd_pop_o     (cmd_pop),
    .res_idle_i    (res_idle),
    .res_we_o      (res_we),
    .res_has_cmp_o (res_has_cmp),
    .res_id_o      (res_id),
    .res_addr_o    (res_addr),
    .res_write_o   (res_write),
    .res_cycle_o   (res_cycle),
    .commit_o      (commit)
  );

  // collect one tick's items; release them with the tick's final flags
  flmrl_out #(
    .ADDR_BITS  (ADDR_BITS),
    .CYCLE_BITS (CYCLE_BITS)
  ) u_out (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .res_we_i         (res_we),
    .res_has_cmp_i    (res_has_cmp),
    .res_id_i         (res_id),
    .res_addr_i       (res_addr),
    .res_write_i      (res_write),
    .res_cycle_i      (res_cycle),
    .commit_i         (commit),
    .idle_o           (res_idle),
    .empty_o          (empty_o),
    .pop_i            (pop_i),
    .has_completion_o (has_completion_o),
    .done_id_o        (done_id_o),
    .done_addr_o      (done_addr_o),
    .done_write_o     (done_write_o),
    .done_cycle_o     (done_cycle_o),
    .still_pending_o  (still_pending_o),
    .overflowed_o     (overflowed_o),
    .last_o           (last_o)
  );

endmodule

// File: tb/sv/tb_fixed_latency_memory_rate_limiter_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fixed_latency_memory_rate_limiter_top
// Self-checking bench for the memory rate limiter. It drives add and tick
// items through the push/full side and pops results on the empty/pop side.
// A scoreboard mirrors the request queue, cycle count and epoch quota, and
// checks each result transfer field by field against the oldest completion
// it predicted.
// ----------------------------------------------------------------------------
module tb_fixed_latency_memory_rate_limiter_top;
  import flmrl_pkg::*;

  localparam int ADDR_W           = ADDR_BITS_DEF;
  localparam int CYC_W            = CYCLE_BITS_DEF;
  localparam int CLK_PERIOD       = 12;
  localparam int RESET_CYCLES     = 4;
  // A tick can drain up to MAX_RESULTS completions; adds may still sit
  // in the command queue after the last result of a tick has gone out.
  localparam int SETTLE_CYCLES    = 64;
  localparam int HOLD_CYCLES      = 150;
  localparam int RUN_LIMIT_CYCLES = 200000;
  localparam int REPORT_LIMIT     = 10;

  // Index 3 has no register behind it; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam logic [LAT_W-1:0]     LAT_MAX        = '1;
  localparam logic [QUOTA_W-1:0]   QUOTA_MAX      = '1;
  localparam logic [EPOCH_W-1:0]   EPOCH_MAX      = '1;

  // One queued request as the scoreboard keeps it.
  typedef struct {
    logic [CYC_W-1:0]  due;
    logic [ADDR_W-1:0] addr;
    logic              write;
    logic [ID_W-1:0]   id;
  } mem_req_t;

  // One result transfer, in port order.
  typedef struct packed {
    logic              has_completion;
    logic [ID_W-1:0]   id;
    logic [ADDR_W-1:0] addr;
    logic              write;
    logic [CYC_W-1:0]  cycle;
    logic              pending;
    logic              overflowed;
    logic              last;
  } tick_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the limiter state and holds the completions still due
  // on the result side.
  // --------------------------------------------------------------------------
  class completion_scoreboard;
    logic [LAT_W-1:0]   latency;
    logic [EPOCH_W-1:0] epoch_len;
    logic [QUOTA_W-1:0] quota;
    logic [CYC_W-1:0]   cycle_cnt;
    logic [EPOCH_W-1:0] epoch_phase;
    logic [QUOTA_W-1:0] served;
    logic [ID_W-1:0]    next_id;
    logic               overflow;
    mem_req_t           mirror_q[$];
    tick_result_t       awaited_q[$];
    int unsigned        mismatches;
    int unsigned        results_seen;
    int unsigned        completions_seen;

    function new();
      latency          = LAT_RST;
      epoch_len        = EPOCH_RST;
      quota            = QUOTA_RST;
      cycle_cnt        = '0;
      epoch_phase      = '0;
      served           = '0;
      next_id          = '0;
      overflow         = 1'b0;
      mismatches       = 0;
      results_seen     = 0;
      completions_seen = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_LATENCY: latency   = data[LAT_W-1:0];
        CFG_EPOCH:   epoch_len = data[EPOCH_W-1:0];
        CFG_QUOTA:   quota     = data[QUOTA_W-1:0];
        default: ;
      endcase
    endfunction

    // Note one accepted input item and queue the results it causes.
    function void note_item(op_e op, logic wr, logic [ADDR_W-1:0] addr);
      mem_req_t         req;
      tick_result_t     res;
      tick_result_t     batch[$];
      logic [CYC_W-1:0] lat;
      int               k;

      if (op == OP_ADD) begin
        // full queue: drop the request, keep the id, set the sticky flag
        if (mirror_q.size() >= QUEUE_DEPTH_DEF) begin
          overflow = 1'b1;
          return;
        end
        lat       = (latency == '0) ? CYC_W'(1) : CYC_W'(latency);
        req.due   = cycle_cnt + lat - CYC_W'(1);
        req.addr  = addr;
        req.write = wr;
        req.id    = next_id;
        next_id   = next_id + 1'b1;
        mirror_q.push_back(req);
        return;
      end

      // tick: drain due requests while the quota and the per-tick cap allow
      while (mirror_q.size() > 0 && batch.size() < MAX_RESULTS) begin
        if (mirror_q[0].due > cycle_cnt || served >= quota) break;
        res                = '0;
        res.has_completion = 1'b1;
        res.id             = mirror_q[0].id;
        res.addr           = mirror_q[0].addr;
        res.write          = mirror_q[0].write;
        res.cycle          = cycle_cnt;
        batch.push_back(res);
        void'(mirror_q.pop_front());
        served = served + 1'b1;
      end

      cycle_cnt   = cycle_cnt + 1'b1;
      epoch_phase = epoch_phase + 1'b1;
      if (epoch_phase >= epoch_len || epoch_phase == '0) begin
        epoch_phase = '0;
        served      = '0;
      end

      // a tick with nothing to report still yields one closing item
      if (batch.size() == 0) begin
        res = '0;
        batch.push_back(res);
      end
      for (k = 0; k < batch.size(); k++) begin
        res            = batch[k];
        res.pending    = (mirror_q.size() > 0);
        res.overflowed = overflow;
        res.last       = (k == batch.size() - 1);
        awaited_q.push_back(res);
      end
    endfunction

    // Check one result transfer against the oldest awaited completion.
    function void check_item(tick_result_t got);
      tick_result_t want;

      results_seen++;
      if (got.has_completion === 1'b1) completions_seen++;
      if (awaited_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("ERROR: result %0d arrived with nothing awaited: cpl %b id %h addr %h",
                   results_seen, got.has_completion, got.id, got.addr);
        return;
      end
      want = awaited_q.pop_front();
      if (got.has_completion !== want.has_completion || got.id !== want.id ||
          got.addr !== want.addr || got.write !== want.write ||
          got.cycle !== want.cycle || got.pending !== want.pending ||
          got.overflowed !== want.overflowed || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("ERROR: result %0d differs", results_seen);
          $display("  expected cpl %b id %h addr %h wr %b cyc %h pend %b ovf %b last %b",
                   want.has_completion, want.id, want.addr, want.write, want.cycle,
                   want.pending, want.overflowed, want.last);
          $display("  actual   cpl %b id %h addr %h wr %b cyc %h pend %b ovf %b last %b",
                   got.has_completion, got.id, got.addr, got.write, got.cycle,
                   got.pending, got.overflowed, got.last);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block interface. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  push_i      = 1'b0;
  logic                  op_i        = 1'b0;
  logic                  req_write_i = 1'b0;
  logic [ADDR_W-1:0]     req_addr_i  = '0;
  logic                  pop_i       = 1'b0;
  logic                  full_o;
  logic                  empty_o;
  logic                  has_completion_o;
  logic [ID_W-1:0]       done_id_o;
  logic [ADDR_W-1:0]     done_addr_o;
  logic                  done_write_o;
  logic [CYC_W-1:0]      done_cycle_o;
  logic                  still_pending_o;
  logic                  overflowed_o;
  logic                  last_o;

  completion_scoreboard board;

  // sender and receiver pacing
  logic        tx_burst = 1'b0;
  logic        hold_rx  = 1'b0;
  int unsigned adds_sent        = 0;
  int unsigned ticks_sent       = 0;
  int unsigned settings_applied = 0;
  int unsigned holds_done       = 0;

  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  fixed_latency_memory_rate_limiter_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .push_i           (push_i),
    .full_o           (full_o),
    .op_i             (op_i),
    .req_write_i      (req_write_i),
    .req_addr_i       (req_addr_i),
    .empty_o          (empty_o),
    .pop_i            (pop_i),
    .has_completion_o (has_completion_o),
    .done_id_o        (done_id_o),
    .done_addr_o      (done_addr_o),
    .done_write_o     (done_write_o),
    .done_cycle_o     (done_cycle_o),
    .still_pending_o  (still_pending_o),
    .overflowed_o     (overflowed_o),
    .last_o           (last_o)
  );

  // --------------------------------------------------------------------------
  // Driver tasks. Each is entered and left on a rising edge; inputs change by
  // nonblocking assignment at that edge, outputs are read at the edge before
  // the block updates them.
  // --------------------------------------------------------------------------

  // Write one register, then hold the enable low before returning so enables never bounce.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.write_register(idx, data);
    @(posedge clk_i);
  endtask

  task automatic apply_setting(input int unsigned lat, input int unsigned epoch,
                               input int unsigned quota);
    write_reg(CFG_LATENCY, CFG_DATA_W'(lat));
    write_reg(CFG_EPOCH, CFG_DATA_W'(epoch));
    write_reg(CFG_QUOTA, CFG_DATA_W'(quota));
    settings_applied++;
  endtask

  // Offer one item and hold it until the transfer. Push stays high into the
  // next item when no gap is drawn.
  task automatic send_item(input op_e op, input logic wr, input logic [ADDR_W-1:0] addr);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      push_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push_i      <= 1'b1;
    op_i        <= op;
    req_write_i <= wr;
    req_addr_i  <= addr;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    board.note_item(op, wr, addr);
    if (op == OP_ADD) adds_sent++;
    else ticks_sent++;
  endtask

  // Stop offering, wait for every awaited result, then let queued adds finish
  // so that a register write lands on an idle block.
  task automatic drain_and_settle();
    push_i <= 1'b0;
    while (board.awaited_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Random mix of adds and ticks; ticks carry random payload that is ignored.
  task automatic run_random_phase(input int unsigned n_items, input int unsigned add_pct);
    int unsigned i;
    for (i = 0; i < n_items; i++) begin
      if (i % 8 == 0) tx_burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < add_pct)
        send_item(OP_ADD, 1'($urandom), ADDR_W'({$urandom, $urandom}));
      else
        send_item(OP_TICK, 1'($urandom), ADDR_W'({$urandom, $urandom}));
    end
    tx_burst = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result side: pop with random gaps, bursts without gaps, and one long hold
  // on request from the stimulus so the block backs up into full_o.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned  gap;
    int unsigned  taken;
    logic         rx_burst;
    tick_result_t got;
    taken    = 0;
    rx_burst = 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (hold_rx) begin
        // hold off; the sender keeps offering items meanwhile
        pop_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_rx = 1'b0;
        holds_done++;
      end
      if (taken % 20 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      gap = rx_burst ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        pop_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop_i <= 1'b1;
      @(posedge clk_i);
      while (empty_o) @(posedge clk_i);
      got = '{has_completion_o, done_id_o, done_addr_o, done_write_o, done_cycle_o,
              still_pending_o, overflowed_o, last_o};
      board.check_item(got);
      taken++;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: directed corners first, then random phases under changing
  // register settings, ending at the largest latency.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned       i;
    int unsigned       ph;
    logic [ADDR_W-1:0] a;
    board = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset setting: bare ticks report no completion and count cycles.
    send_item(OP_TICK, 1'b0, '0);
    send_item(OP_TICK, 1'b1, '1);
    drain_and_settle();

    // Latency zero acts as the smallest nonzero latency, epoch zero clears the quota on every tick,
    // quota at its top. The write to the unused index must change nothing.
    apply_setting(0, 0, QUOTA_MAX);
    write_reg(CFG_UNUSED_IDX, '1);

    // Fill the queue to the brim, then one more add that gets dropped.
    for (i = 0; i <= QUEUE_DEPTH_DEF; i++) begin
      if (i == 0) a = '0;
      else if (i == 1) a = '1;
      else a = (ADDR_W'(1) << (i * 3)) ^ ADDR_W'(48'h5555_5555_5555 >> i);
      send_item(OP_ADD, i[0], a);
    end
    // One tick drains all sixteen at the per-tick cap; the next one is empty
    // and still reports the sticky overflow.
    send_item(OP_TICK, 1'b0, '0);
    send_item(OP_TICK, 1'b0, '0);
    drain_and_settle();

    // Quota zero: nothing completes, the request stays pending.
    apply_setting(1, EPOCH_MAX, 0);
    send_item(OP_ADD, 1'b1, ADDR_W'(48'hA5A5_0F0F_F0F0));
    send_item(OP_TICK, 1'b0, '0);
    send_item(OP_TICK, 1'b0, '0);
    drain_and_settle();

    // Random phases with short latencies so completions flow; one phase lifts
    // the quota so ticks drain several requests at once.
    for (ph = 0; ph < 4; ph++) begin
      apply_setting($urandom_range(1, 6), $urandom_range(1, 8),
                    (ph == 2) ? QUOTA_MAX : $urandom_range(1, 4));
      if (ph == 0) hold_rx = 1'b1;
      run_random_phase(20, $urandom_range(40, 75));
      drain_and_settle();
    end

    // Largest latency: new requests never come due within the run.
    apply_setting(LAT_MAX, $urandom_range(1, EPOCH_MAX), QUOTA_MAX);
    run_random_phase(12, 50);
    drain_and_settle();

    $display("Run covered %0d adds and %0d ticks under %0d register settings, %0d long hold(s).",
             adds_sent, ticks_sent, settings_applied, holds_done);
    $display("Checked %0d result transfers (%0d completions), %0d mismatches.",
             board.results_seen, board.completions_seen, board.mismatches);
    if (board.mismatches == 0 && board.awaited_q.size() == 0) begin
      $display("tb_fixed_latency_memory_rate_limiter_top OK");
    end else begin
      $display("tb_fixed_latency_memory_rate_limiter_top NOT OK");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #(RUN_LIMIT_CYCLES * CLK_PERIOD);
    $display("Timeout after %0d cycles", RUN_LIMIT_CYCLES);
    $display("tb_fixed_latency_memory_rate_limiter_top NOT OK");
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/flmrl_pkg.sv
sv/flmrl_front.sv
sv/flmrl_back.sv
sv/flmrl_out.sv
sv/fixed_latency_memory_rate_limiter_top.sv
tb/sv/tb_fixed_latency_memory_rate_limiter_top.sv
